@@ rtl/core/vdf_pkg.sv @@
// shared types and constants of the velocity drag force core
package vdf_pkg;

	// register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAD   = 1'b1;

	// square root pipeline: 32 result bits, two per stage
	localparam int unsigned SQRT_STAGES = 16;
	localparam int unsigned SQRT_STEPS  = 2;

	// velocity magnitudes and signs carried alongside the square root
	typedef struct packed {
		logic        xn;
		logic [31:0] xm;
		logic        yn;
		logic [31:0] ym;
	} vdf_vel_t;

endpackage

@@ rtl/core/vdf_isqrt.sv @@
// pipelined floor square root of a 64-bit radicand, two root bits per stage
module vdf_isqrt import vdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] radicand,
	input  vdf_vel_t    in_vel,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] root,
	output vdf_vel_t    out_vel
);

	logic [SQRT_STAGES-1:0] v_s;
	logic [SQRT_STAGES-1:0] ld;
	logic [33:0]            rem_s  [SQRT_STAGES];
	logic [31:0]            root_s [SQRT_STAGES];
	logic [63:0]            rad_s  [SQRT_STAGES];
	vdf_vel_t               vel_s  [SQRT_STAGES];

	genvar k;
	for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic        v_in;
		logic [33:0] rem_in;
		logic [31:0] root_in;
		logic [63:0] rad_in;
		vdf_vel_t    vel_in;
		logic [33:0] rem_nx;
		logic [31:0] root_nx;
		logic [63:0] rad_nx;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = radicand;
			assign vel_in  = in_vel;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign vel_in  = vel_s[k-1];
		end

		// a stage loads when empty or when the one after it moves
		if (k == SQRT_STAGES - 1) begin : g_last
			assign ld[k] = !v_s[k] || out_ready;
		end else begin : g_mid
			assign ld[k] = !v_s[k] || ld[k+1];
		end

		// restoring digit recurrence: bring down two radicand bits per root bit
		always_comb begin
			logic [33:0] trial;
			rem_nx  = rem_in;
			root_nx = root_in;
			rad_nx  = rad_in;
			for (int j = 0; j < SQRT_STEPS; j++) begin
				rem_nx = {rem_nx[31:0], rad_nx[63:62]};
				rad_nx = {rad_nx[61:0], 2'b00};
				trial  = {root_nx, 2'b01};
				if (rem_nx >= trial) begin
					rem_nx  = rem_nx - trial;
					root_nx = {root_nx[30:0], 1'b1};
				end else begin
					root_nx = {root_nx[30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (ld[k]) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ld[k]) begin
				rem_s[k]  <= rem_nx;
				root_s[k] <= root_nx;
				rad_s[k]  <= rad_nx;
				vel_s[k]  <= vel_in;
			end
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = v_s[SQRT_STAGES-1];
	assign root      = root_s[SQRT_STAGES-1];
	assign out_vel   = vel_s[SQRT_STAGES-1];

endmodule

@@ rtl/core/velocity_drag_force_core.sv @@
// top level of the velocity drag force core: linear plus quadratic drag impulse
//
//  channel    | handshake                        | payload
//  -----------+----------------------------------+----------------------------------------
//  velocity   | velocity_valid / velocity_stall  | velocity_x, velocity_y (signed Q16.16)
//  force      | force_valid / force_stall        | force_x, force_y, applied, saturated
//  config     | cfg_write_en                     | cfg_index, cfg_data
//
// one word enters per cycle while velocity_stall is low
// most of the latency comes from the 32-bit square root, two root bits per stage over 16 stages
// every stage has its own valid bit and loads when empty or when its successor moves,
// so bubbles close up and a stalled output word holds while the pipe keeps filling
// arst_n clears all valid bits and both coefficients; payload registers are not reset
module velocity_drag_force_core import vdf_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 velocity_valid,
	output logic                 velocity_stall,
	input  logic signed [31:0]   velocity_x,
	input  logic signed [31:0]   velocity_y,
	output logic                 force_valid,
	input  logic                 force_stall,
	output logic signed [31:0]   force_x,
	output logic signed [31:0]   force_y,
	output logic                 applied,
	output logic                 saturated
);

	localparam int unsigned HI_SHIFT = 32 - FRAC_BITS;
	localparam logic [63:0] P1_LIMIT = 64'd1 << FRAC_BITS;
	localparam logic [63:0] SAT_POS  = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] SAT_NEG  = 64'h0000_0000_8000_0000;

	// coefficient registers
	logic [31:0] linear_q;
	logic [31:0] quad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linear_q <= '0;
			quad_q   <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_LINEAR: linear_q <= cfg_data;
				REG_QUAD:   quad_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// k2 as sign and magnitude; the user must keep it static while words are in flight, the block does not enforce this
	logic        k2n;
	logic [31:0] k2m;
	logic [63:0] k1_ext;
	assign k2n    = quad_q[31];
	assign k2m    = k2n ? (~quad_q + 32'd1) : quad_q;
	assign k1_ext = {{32{linear_q[31]}}, linear_q};

	// pipeline valid bits and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, force_valid_q;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6, ld_s7, ld_s8, ld_out;
	logic sq_in_ready, sq_valid;

	assign ld_out = !force_valid_q || !force_stall;
	assign ld_s8  = !v_s8 || ld_out;
	assign ld_s7  = !v_s7 || ld_s8;
	assign ld_s6  = !v_s6 || ld_s7;
	assign ld_s5  = !v_s5 || ld_s6;
	assign ld_s4  = !v_s4 || ld_s5;
	assign ld_s3  = !v_s3 || sq_in_ready;
	assign ld_s2  = !v_s2 || ld_s3;
	assign ld_s1  = !v_s1 || ld_s2;

	assign velocity_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			v_s5          <= 1'b0;
			v_s6          <= 1'b0;
			v_s7          <= 1'b0;
			v_s8          <= 1'b0;
			force_valid_q <= 1'b0;
		end else begin
			if (ld_s1)  v_s1          <= velocity_valid;
			if (ld_s2)  v_s2          <= v_s1;
			if (ld_s3)  v_s3          <= v_s2;
			if (ld_s4)  v_s4          <= sq_valid;
			if (ld_s5)  v_s5          <= v_s4;
			if (ld_s6)  v_s6          <= v_s5;
			if (ld_s7)  v_s7          <= v_s6;
			if (ld_s8)  v_s8          <= v_s7;
			if (ld_out) force_valid_q <= v_s8;
		end
	end

	// stage 1: sign and magnitude of each component
	vdf_vel_t vel_in;
	assign vel_in.xn = velocity_x[31];
	assign vel_in.xm = velocity_x[31] ? (~velocity_x + 32'sd1) : velocity_x;
	assign vel_in.yn = velocity_y[31];
	assign vel_in.ym = velocity_y[31] ? (~velocity_y + 32'sd1) : velocity_y;

	vdf_vel_t    vel_s1, vel_s2, vel_s3, vel_s4, vel_s5, vel_s6;
	logic [63:0] xsq_s2, ysq_s2, sum_s3;

	always_ff @(posedge clk) begin
		if (ld_s1) vel_s1 <= vel_in;
		// stage 2: squares
		if (ld_s2) begin
			vel_s2 <= vel_s1;
			xsq_s2 <= 64'(vel_s1.xm) * 64'(vel_s1.xm);
			ysq_s2 <= 64'(vel_s1.ym) * 64'(vel_s1.ym);
		end
		// stage 3: sum of squares, at most 2^63
		if (ld_s3) begin
			vel_s3 <= vel_s2;
			sum_s3 <= xsq_s2 + ysq_s2;
		end
	end

	// square root pipeline
	logic [31:0] sq_root;
	vdf_vel_t    sq_vel;

	vdf_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.radicand  (sum_s3),
		.in_vel    (vel_s3),
		.in_ready  (sq_in_ready),
		.out_valid (sq_valid),
		.out_ready (ld_s4),
		.root      (sq_root),
		.out_vel   (sq_vel)
	);

	logic        zero_s4, zero_s5, zero_s6, zero_s7, zero_s8;
	logic [63:0] kprod_s4, c_s5, cm_s6;
	logic        cn_s6;
	logic [63:0] px0_s7, px1_s7, py0_s7, py1_s7;
	logic        xn_s7, yn_s7, cn_s7;
	logic [63:0] mx_s8, my_s8;
	logic        bigx_s8, bigy_s8, negx_s8, negy_s8;
	logic [63:0] q_full;

	assign q_full = kprod_s4 >> FRAC_BITS;

	always_ff @(posedge clk) begin
		// stage 4: k2 times speed
		if (ld_s4) begin
			vel_s4   <= sq_vel;
			zero_s4  <= (sq_root == 32'd0);
			kprod_s4 <= 64'(k2m) * 64'(sq_root);
		end
		// stage 5: coefficient c = k1 + k2*s, exact in 64 bits
		if (ld_s5) begin
			vel_s5  <= vel_s4;
			zero_s5 <= zero_s4;
			c_s5    <= k2n ? (k1_ext - q_full) : (k1_ext + q_full);
		end
		// stage 6: sign and magnitude of c
		if (ld_s6) begin
			vel_s6  <= vel_s5;
			zero_s6 <= zero_s5;
			cn_s6   <= c_s5[63];
			cm_s6   <= c_s5[63] ? (~c_s5 + 64'd1) : c_s5;
		end
		// stage 7: partial products of |v| by |c|, low and high halves
		if (ld_s7) begin
			zero_s7 <= zero_s6;
			xn_s7   <= vel_s6.xn;
			yn_s7   <= vel_s6.yn;
			cn_s7   <= cn_s6;
			px0_s7  <= 64'(vel_s6.xm) * 64'(cm_s6[31:0]);
			px1_s7  <= 64'(vel_s6.xm) * 64'(cm_s6[63:32]);
			py0_s7  <= 64'(vel_s6.ym) * 64'(cm_s6[31:0]);
			py1_s7  <= 64'(vel_s6.ym) * 64'(cm_s6[63:32]);
		end
		// stage 8: scaled magnitude, high overflow flags, result sign
		if (ld_s8) begin
			zero_s8 <= zero_s7;
			bigx_s8 <= (px1_s7 >= P1_LIMIT);
			bigy_s8 <= (py1_s7 >= P1_LIMIT);
			mx_s8   <= (px1_s7 << HI_SHIFT) + (px0_s7 >> FRAC_BITS);
			my_s8   <= (py1_s7 << HI_SHIFT) + (py0_s7 >> FRAC_BITS);
			// force opposes v: negative when v and c share a sign
			negx_s8 <= (xn_s7 == cn_s7);
			negy_s8 <= (yn_s7 == cn_s7);
		end
	end

	// output stage: clamp to the signed range and apply the sign
	logic [63:0] limx, limy;
	logic        satx, saty;
	logic [31:0] magx, magy;
	logic [31:0] fx_nx, fy_nx;

	always_comb begin
		limx  = negx_s8 ? SAT_NEG : SAT_POS;
		limy  = negy_s8 ? SAT_NEG : SAT_POS;
		satx  = bigx_s8 || (mx_s8 > limx);
		saty  = bigy_s8 || (my_s8 > limy);
		magx  = satx ? limx[31:0] : mx_s8[31:0];
		magy  = saty ? limy[31:0] : my_s8[31:0];
		fx_nx = negx_s8 ? (~magx + 32'd1) : magx;
		fy_nx = negy_s8 ? (~magy + 32'd1) : magy;
	end

	logic [31:0] force_x_q, force_y_q;
	logic        applied_q, saturated_q;

	always_ff @(posedge clk) begin
		if (ld_out) begin
			// zero speed: no impulse and no flags
			force_x_q   <= zero_s8 ? 32'd0 : fx_nx;
			force_y_q   <= zero_s8 ? 32'd0 : fy_nx;
			applied_q   <= !zero_s8;
			saturated_q <= !zero_s8 && (satx || saty);
		end
	end

	assign force_valid = force_valid_q;
	assign force_x     = force_x_q;
	assign force_y     = force_y_q;
	assign applied     = applied_q;
	assign saturated   = saturated_q;

endmodule
